@@ src/microprogram_next_address_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the microprogram next-address block
// Clocked property checks on clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef MICROPROGRAM_NEXT_ADDRESS_DEFINES_SVH
`define MICROPROGRAM_NEXT_ADDRESS_DEFINES_SVH

// checked only outside reset
`define MNA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// checked at every edge, reset included
`define MNA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

@@ src/mna_pkg.sv @@
// ----------------------------------------------------------------------------
// mna_pkg
// Types and constants shared by the microprogram next-address block.
// ----------------------------------------------------------------------------
package mna_pkg;

	localparam int ADDR_W  = 6;
	localparam int WORD_W  = 32;
	localparam int KEY_W   = 8;
	localparam int KIND_W  = 4;
	localparam int SHIFT_W = 5;
	localparam int FWID_W  = 3;

	// dispatch scan handles this many entries per cycle
	localparam int SCAN_LANES = 8;
	localparam int LANE_W     = 3;

	typedef enum logic [1:0] {
		OP_LOAD_WORD  = 2'd0,
		OP_LOAD_ENTRY = 2'd1,
		OP_STEP       = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	localparam logic CFG_JUMP_SHIFT = 1'b0;
	localparam logic CFG_JUMP_WIDTH = 1'b1;

	localparam logic [SHIFT_W-1:0] JUMP_SHIFT_RESET = 5'd28;
	localparam logic [FWID_W-1:0]  JUMP_WIDTH_RESET = 3'd4;
	localparam logic [FWID_W-1:0]  JUMP_WIDTH_MAX   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_ZERO  = 4'd0;
	localparam logic [KIND_W-1:0] KIND_DISP1 = 4'd1;
	localparam logic [KIND_W-1:0] KIND_DISP2 = 4'd2;
	localparam logic [KIND_W-1:0] KIND_INC   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DISP3 = 4'd4;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] micro_word;
		logic [KEY_W-1:0]  instr_opcode;
		logic [ADDR_W-1:0] target_one;
		logic              target_one_ok;
		logic [ADDR_W-1:0] target_two;
		logic              target_two_ok;
		logic [ADDR_W-1:0] target_three;
		logic              target_three_ok;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] control_word;
		logic [ADDR_W-1:0] next_address;
		logic              unsupported;
		logic [KIND_W-1:0] jump_kind;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] target_one;
		logic              ok_one;
		logic [ADDR_W-1:0] target_two;
		logic              ok_two;
		logic [ADDR_W-1:0] target_three;
		logic              ok_three;
	} disp_entry_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] address;
		logic              in_store;
		logic              in_table;
		logic [WORD_W-1:0] micro_word;
		disp_entry_t       entry;
	} cmd_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] shift;
		logic [FWID_W-1:0]  width;
	} cfg_t;

	typedef enum logic {
		B_IDLE = 1'b0,
		B_SCAN = 1'b1
	} back_state_t;

endpackage

@@ src/mna_ram.sv @@
// ----------------------------------------------------------------------------
// mna_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mna_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/mna_front.sv @@
// ----------------------------------------------------------------------------
// mna_front
// Accepts requests, decodes and range-checks them, and holds them in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
`include "microprogram_next_address_defines.svh"

module mna_front #(
	parameter int STORE_DEPTH      = 64,
	parameter int DISPATCH_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mna_pkg::in_item_t item,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output mna_pkg::cmd_t     cmd
);

	mna_pkg::cmd_t cmd_d;
	mna_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		cmd_d                    = '0;
		cmd_d.op                 = mna_pkg::op_t'(item.opcode);
		cmd_d.address            = item.address;
		cmd_d.in_store           = 32'(item.address) < STORE_DEPTH;
		cmd_d.in_table           = 32'(item.address) < DISPATCH_ENTRIES;
		cmd_d.micro_word         = item.micro_word;
		// on a step the key field carries the opcode to look up
		cmd_d.entry.key          = item.instr_opcode;
		cmd_d.entry.target_one   = item.target_one;
		cmd_d.entry.ok_one       = item.target_one_ok;
		cmd_d.entry.target_two   = item.target_two;
		cmd_d.entry.ok_two       = item.target_two_ok;
		cmd_d.entry.target_three = item.target_three;
		cmd_d.entry.ok_three     = item.target_three_ok;
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`MNA_ASSERT_ALWAYS(a_front_cnt_max, cnt_q != 2'd3, "command queue count out of range")
	`MNA_ASSERT(a_front_pop_nonempty, cmd_pop |-> cmd_valid, "back end pops an empty queue")
	`MNA_ASSERT(a_front_fill, (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1, "request lost")

endmodule

@@ src/mna_back.sv @@
// ----------------------------------------------------------------------------
// mna_back
// Executes commands: control store and dispatch table writes, and steps
// that read the store, scan the dispatch keys and pick the next address.
// Results wait in a two-entry output queue.
// ----------------------------------------------------------------------------
`include "microprogram_next_address_defines.svh"

module mna_back #(
	parameter int STORE_DEPTH      = 64,
	parameter int DISPATCH_ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mna_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  mna_pkg::cmd_t      cmd,
	output logic               empty,
	input  logic               pop,
	output mna_pkg::out_item_t result
);

	localparam int AW         = $clog2(STORE_DEPTH);
	localparam int EW         = (DISPATCH_ENTRIES > 1) ? $clog2(DISPATCH_ENTRIES) : 1;
	localparam int SCAN_STEPS = (DISPATCH_ENTRIES + mna_pkg::SCAN_LANES - 1)
	                            / mna_pkg::SCAN_LANES;
	localparam int SW         = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;
	localparam int MV_W       = SCAN_STEPS * mna_pkg::SCAN_LANES;

	mna_pkg::back_state_t state_q, state_d;

	mna_pkg::disp_entry_t table_q [DISPATCH_ENTRIES];
	logic                 tbl_we;

	logic                            ram_we;
	logic                            ram_re;
	logic [mna_pkg::WORD_W-1:0]      rdata;

	logic [MV_W-1:0]                 match_d;
	logic [MV_W-1:0]                 match_q;
	logic [SW-1:0]                   step_q;
	logic [mna_pkg::ADDR_W-1:0]      addr_q;
	logic                            in_store_q;

	logic                            hit;
	logic                            last;
	logic [mna_pkg::LANE_W-1:0]      lane_idx;
	logic [EW-1:0]                   hit_idx;
	mna_pkg::disp_entry_t            hit_entry;
	logic [mna_pkg::WORD_W-1:0]      word;
	logic [mna_pkg::FWID_W-1:0]      eff_width;
	logic [4:0]                      mask5;
	logic [mna_pkg::KIND_W-1:0]      kind;
	logic [mna_pkg::ADDR_W:0]        inc;
	logic [mna_pkg::ADDR_W-1:0]      next_addr;
	logic                            unsup;
	mna_pkg::out_item_t              step_res;
	logic                            step_go;

	mna_pkg::out_item_t              res_mem_q [2];
	logic                            res_wr_q;
	logic                            res_rd_q;
	logic [1:0]                      res_cnt_q;
	logic                            res_push;
	mna_pkg::out_item_t              res_data;
	logic                            res_pop;
	logic                            res_room;

	mna_ram #(
		.WIDTH (mna_pkg::WORD_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.address)),
		.wdata (cmd.micro_word),
		.re    (ram_re),
		.raddr (AW'(cmd.address)),
		.rdata (rdata)
	);

	// key compare against every entry, registered for the scan
	always_comb begin
		match_d = '0;
		for (int i = 0; i < DISPATCH_ENTRIES; i++) begin
			match_d[i] = table_q[i].key == cmd.entry.key;
		end
	end

	// first match within the current group of lanes
	always_comb begin
		lane_idx = '0;
		for (int l = mna_pkg::SCAN_LANES - 1; l >= 0; l--) begin
			if (match_q[l]) begin
				lane_idx = mna_pkg::LANE_W'(l);
			end
		end
	end

	assign hit       = |match_q[mna_pkg::SCAN_LANES-1:0];
	assign last      = step_q == SW'(SCAN_STEPS - 1);
	assign hit_idx   = EW'({step_q, lane_idx});
	assign hit_entry = table_q[hit_idx];

	assign word      = in_store_q ? rdata : '0;
	assign eff_width = (cfg.width > mna_pkg::JUMP_WIDTH_MAX) ? mna_pkg::JUMP_WIDTH_MAX
	                                                         : cfg.width;
	assign mask5     = (5'd1 << eff_width) - 5'd1;
	assign kind      = mna_pkg::KIND_W'(word >> cfg.shift) & mask5[mna_pkg::KIND_W-1:0];
	assign inc       = {1'b0, addr_q} + (mna_pkg::ADDR_W + 1)'(1);

	always_comb begin
		next_addr = addr_q;
		unsup     = 1'b0;
		case (kind)
			mna_pkg::KIND_ZERO: begin
				next_addr = '0;
			end
			mna_pkg::KIND_INC: begin
				next_addr = (32'(inc) >= STORE_DEPTH) ? '0 : inc[mna_pkg::ADDR_W-1:0];
			end
			mna_pkg::KIND_DISP1: begin
				next_addr = (hit && hit_entry.ok_one) ? hit_entry.target_one : '0;
				unsup     = hit && !hit_entry.ok_one;
			end
			mna_pkg::KIND_DISP2: begin
				next_addr = (hit && hit_entry.ok_two) ? hit_entry.target_two : '0;
				unsup     = hit && !hit_entry.ok_two;
			end
			mna_pkg::KIND_DISP3: begin
				next_addr = (hit && hit_entry.ok_three) ? hit_entry.target_three : '0;
				unsup     = hit && !hit_entry.ok_three;
			end
			default: begin
				next_addr = addr_q;
			end
		endcase
	end

	always_comb begin
		step_res              = '0;
		step_res.control_word = word;
		step_res.next_address = next_addr;
		step_res.unsupported  = unsup;
		step_res.jump_kind    = kind;
	end

	assign res_room = res_cnt_q != 2'd2;
	assign step_go  = cmd_pop && cmd.op == mna_pkg::OP_STEP;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		tbl_we   = 1'b0;
		res_push = 1'b0;
		res_data = '0;
		case (state_q)
			mna_pkg::B_IDLE: begin
				if (cmd_valid && res_room) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						mna_pkg::OP_LOAD_WORD: begin
							ram_we   = cmd.in_store;
							res_push = 1'b1;
						end
						mna_pkg::OP_LOAD_ENTRY: begin
							tbl_we   = cmd.in_table;
							res_push = 1'b1;
						end
						mna_pkg::OP_STEP: begin
							ram_re  = cmd.in_store;
							state_d = mna_pkg::B_SCAN;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			mna_pkg::B_SCAN: begin
				// room was reserved when the step was taken
				if (hit || last) begin
					res_push = 1'b1;
					res_data = step_res;
					state_d  = mna_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = mna_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mna_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DISPATCH_ENTRIES; i++) begin
				table_q[i] <= '0;
			end
		end else if (tbl_we) begin
			table_q[EW'(cmd.address)] <= cmd.entry;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mna_pkg::B_IDLE) begin
			match_q    <= match_d;
			step_q     <= '0;
			addr_q     <= cmd.address;
			in_store_q <= cmd.in_store;
		end else begin
			match_q <= match_q >> mna_pkg::SCAN_LANES;
			step_q  <= step_q + SW'(1);
		end
	end

	// result queue
	assign empty   = res_cnt_q == 2'd0;
	assign result  = res_mem_q[res_rd_q];
	assign res_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= !res_rd_q;
			end
			case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	`MNA_ASSERT(a_back_no_overflow, res_push |-> (res_cnt_q != 2'd2 || res_pop), "result overflow")
	`MNA_ASSERT(a_back_scan_hold, state_q == mna_pkg::B_SCAN |-> !cmd_pop, "command taken mid-step")
	`MNA_ASSERT(a_back_step_start, step_go |=> state_q == mna_pkg::B_SCAN, "step not started")

endmodule

@@ src/microprogram_next_address.sv @@
// ----------------------------------------------------------------------------
// microprogram_next_address
// Microcode sequencer with control store and opcode dispatch table.
// ----------------------------------------------------------------------------
// Requests enter through a two-entry command queue and results leave through
// a two-entry result queue. Requests are executed one at a time: a control
// word or dispatch entry load is done in the execute unit as it is taken, and
// a step reads the control store and then scans the dispatch table in
// eight-entry groups up to the first matching key (at most
// ceil(DISPATCH_ENTRIES/8) groups); no new request is taken during a step.
// A result is registered into the result queue when execution ends. The
// control store has no reset: stepping an address never loaded gives an
// undefined word. The dispatch table resets to all zero.
module microprogram_next_address #(
	parameter int STORE_DEPTH      = 64,
	parameter int DISPATCH_ENTRIES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  mna_pkg::in_item_t                  item,
	output logic                               empty,
	input  logic                               pop,
	output mna_pkg::out_item_t                 result,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [mna_pkg::SHIFT_W-1:0]        cfg_data
);

	mna_pkg::cfg_t cfg_q;
	mna_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shift <= mna_pkg::JUMP_SHIFT_RESET;
			cfg_q.width <= mna_pkg::JUMP_WIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mna_pkg::CFG_JUMP_SHIFT: cfg_q.shift <= cfg_data;
				mna_pkg::CFG_JUMP_WIDTH: cfg_q.width <= cfg_data[mna_pkg::FWID_W-1:0];
				default:                 cfg_q       <= cfg_q;
			endcase
		end
	end

	mna_front #(
		.STORE_DEPTH      (STORE_DEPTH),
		.DISPATCH_ENTRIES (DISPATCH_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	mna_back #(
		.STORE_DEPTH      (STORE_DEPTH),
		.DISPATCH_ENTRIES (DISPATCH_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ test/next_address_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// next_address_checker
// Watches the request, result and field-setting ports of the sequencer. It
// keeps its own control store, dispatch table and jump-field setting, works
// out the result of every accepted request and compares each popped result
// with the oldest outstanding one.
// ----------------------------------------------------------------------------
module next_address_checker #(
	parameter int STORE_DEPTH      = 64,
	parameter int DISPATCH_ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        full,
	input  mna_pkg::in_item_t           item,
	input  logic                        empty,
	input  logic                        pop,
	input  mna_pkg::out_item_t          result,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mna_pkg::SHIFT_W-1:0] cfg_data,
	output int                          mismatches,
	output int                          outstanding
);

	logic [mna_pkg::WORD_W-1:0]  store_words [STORE_DEPTH];
	mna_pkg::disp_entry_t        table_entries [DISPATCH_ENTRIES];
	logic [mna_pkg::SHIFT_W-1:0] field_shift;
	logic [mna_pkg::FWID_W-1:0]  field_width;
	mna_pkg::out_item_t          results_due [$];
	mna_pkg::out_item_t          oldest;
	mna_pkg::out_item_t          predicted;

	// applies one request to the local copy of the state and returns its result
	function automatic mna_pkg::out_item_t sequence_request(input mna_pkg::in_item_t req);
		mna_pkg::out_item_t         r;
		logic [mna_pkg::FWID_W-1:0] w;
		logic [mna_pkg::WORD_W-1:0] mask;
		mna_pkg::disp_entry_t       hit;
		logic                       found;
		logic                       hit_ok;
		logic [mna_pkg::ADDR_W-1:0] hit_target;
		int                         nxt;
		r = '0;
		found = 1'b0;
		hit = '0;
		case (req.opcode)
		mna_pkg::OP_LOAD_WORD: begin
			if (req.address < STORE_DEPTH)
				store_words[req.address] = req.micro_word;
		end
		mna_pkg::OP_LOAD_ENTRY: begin
			if (req.address < DISPATCH_ENTRIES) begin
				table_entries[req.address].key          = req.instr_opcode;
				table_entries[req.address].target_one   = req.target_one;
				table_entries[req.address].ok_one       = req.target_one_ok;
				table_entries[req.address].target_two   = req.target_two;
				table_entries[req.address].ok_two       = req.target_two_ok;
				table_entries[req.address].target_three = req.target_three;
				table_entries[req.address].ok_three     = req.target_three_ok;
			end
		end
		mna_pkg::OP_STEP: begin
			r.control_word = (req.address < STORE_DEPTH) ? store_words[req.address] : '0;
			w = (field_width > mna_pkg::JUMP_WIDTH_MAX) ? mna_pkg::JUMP_WIDTH_MAX
				: field_width;
			// width zero gives an empty mask and so kind zero
			mask = (32'd1 << w) - 32'd1;
			r.jump_kind = mna_pkg::KIND_W'((r.control_word >> field_shift) & mask);
			case (r.jump_kind)
			mna_pkg::KIND_ZERO: r.next_address = '0;
			mna_pkg::KIND_INC: begin
				nxt = int'(req.address) + 1;
				if (nxt >= STORE_DEPTH)
					nxt = 0;
				r.next_address = mna_pkg::ADDR_W'(nxt);
			end
			mna_pkg::KIND_DISP1, mna_pkg::KIND_DISP2, mna_pkg::KIND_DISP3: begin
				for (int i = 0; i < DISPATCH_ENTRIES; i++) begin
					if (!found && table_entries[i].key == req.instr_opcode) begin
						found = 1'b1;
						hit = table_entries[i];
					end
				end
				case (r.jump_kind)
				mna_pkg::KIND_DISP1: begin
					hit_ok = hit.ok_one;
					hit_target = hit.target_one;
				end
				mna_pkg::KIND_DISP2: begin
					hit_ok = hit.ok_two;
					hit_target = hit.target_two;
				end
				default: begin
					hit_ok = hit.ok_three;
					hit_target = hit.target_three;
				end
				endcase
				// no matching key: target zero, treated as supported
				if (!found)
					r.next_address = '0;
				else if (hit_ok)
					r.next_address = hit_target;
				else
					r.unsupported = 1'b1;
			end
			default: r.next_address = req.address;
			endcase
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [mna_pkg::WORD_W-1:0] want,
			input logic [mna_pkg::WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_shift = mna_pkg::JUMP_SHIFT_RESET;
			field_width = mna_pkg::JUMP_WIDTH_RESET;
			for (int i = 0; i < DISPATCH_ENTRIES; i++)
				table_entries[i] = '0;
			results_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					$error("result %h popped with no request outstanding", result);
					mismatches++;
				end else begin
					oldest = results_due.pop_front();
					check_field("control_word", oldest.control_word, result.control_word);
					check_field("next_address", mna_pkg::WORD_W'(oldest.next_address),
						mna_pkg::WORD_W'(result.next_address));
					check_field("unsupported", mna_pkg::WORD_W'(oldest.unsupported),
						mna_pkg::WORD_W'(result.unsupported));
					check_field("jump_kind", mna_pkg::WORD_W'(oldest.jump_kind),
						mna_pkg::WORD_W'(result.jump_kind));
				end
			end
			if (cfg_we) begin
				if (cfg_index == mna_pkg::CFG_JUMP_SHIFT)
					field_shift = cfg_data;
				else
					field_width = cfg_data[mna_pkg::FWID_W-1:0];
			end
			if (push && !full) begin
				predicted = sequence_request(item);
				results_due = {results_due, predicted};
			end
			outstanding = results_due.size();
		end
	end

endmodule

@@ test/tb_microprogram_next_address.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_microprogram_next_address
// Drives control-word loads, dispatch-entry loads and steps into the
// sequencer with random gaps and random result back-pressure, over a series
// of jump-field settings; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_microprogram_next_address;

	localparam int STORE_DEPTH      = 64;
	localparam int DISPATCH_ENTRIES = 16;
	localparam int RANDOM_REQUESTS  = 1100;
	localparam int PHASES           = 8;
	localparam int SETTLE_CYCLES    = 16;
	localparam int STALL_LIMIT      = 2000;

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	mna_pkg::in_item_t           item;
	logic                        empty;
	logic                        pop;
	mna_pkg::out_item_t          result;
	logic                        cfg_we;
	logic                        cfg_index;
	logic [mna_pkg::SHIFT_W-1:0] cfg_data;
	int                          mismatches;
	int                          outstanding;

	// stimulus bookkeeping: only addresses already loaded are ever stepped
	logic                        loaded [STORE_DEPTH];
	int                          loaded_addrs [$];
	logic [mna_pkg::KEY_W-1:0]   slot_keys [DISPATCH_ENTRIES];
	logic [mna_pkg::SHIFT_W-1:0] cur_shift;
	logic [mna_pkg::FWID_W-1:0]  cur_width;
	bit                          feed_bursty;
	bit                          drain_bursty;
	int                          sent;
	int                          steps_sent;
	int                          quiet_cycles;

	microprogram_next_address #(
		.STORE_DEPTH      (STORE_DEPTH),
		.DISPATCH_ENTRIES (DISPATCH_ENTRIES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	next_address_checker #(
		.STORE_DEPTH      (STORE_DEPTH),
		.DISPATCH_ENTRIES (DISPATCH_ENTRIES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// every field random, then opcode and address as asked
	function automatic mna_pkg::in_item_t noisy_request(input mna_pkg::op_t op, input int addr);
		mna_pkg::in_item_t req;
		req.opcode          = op;
		req.address         = mna_pkg::ADDR_W'(addr);
		req.micro_word      = $urandom;
		req.instr_opcode    = mna_pkg::KEY_W'($urandom_range(0, 255));
		req.target_one      = mna_pkg::ADDR_W'($urandom_range(0, 63));
		req.target_one_ok   = 1'($urandom_range(0, 1));
		req.target_two      = mna_pkg::ADDR_W'($urandom_range(0, 63));
		req.target_two_ok   = 1'($urandom_range(0, 1));
		req.target_three    = mna_pkg::ADDR_W'($urandom_range(0, 63));
		req.target_three_ok = 1'($urandom_range(0, 1));
		return req;
	endfunction

	function automatic mna_pkg::in_item_t random_request();
		mna_pkg::in_item_t          req;
		int                         pick;
		logic [mna_pkg::FWID_W-1:0] w;
		logic [mna_pkg::WORD_W-1:0] mask;
		logic [mna_pkg::KIND_W-1:0] kind;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			req = noisy_request(mna_pkg::OP_NONE, $urandom_range(0, 63));
		end else if (pick < 25 || loaded_addrs.size() == 0) begin
			req = noisy_request(mna_pkg::OP_LOAD_WORD,
				($urandom_range(0, 9) == 0) ? STORE_DEPTH - 1 : $urandom_range(0, 63));
			// mostly plant a chosen jump kind where the current setting reads it
			if ($urandom_range(0, 4) != 0) begin
				kind = ($urandom_range(0, 3) == 0)
					? mna_pkg::KIND_W'($urandom_range(0, 15))
					: mna_pkg::KIND_W'($urandom_range(0, 4));
				w = (cur_width > mna_pkg::JUMP_WIDTH_MAX) ? mna_pkg::JUMP_WIDTH_MAX
					: cur_width;
				mask = (32'd1 << w) - 32'd1;
				req.micro_word = (req.micro_word & ~(mask << cur_shift))
					| ((mna_pkg::WORD_W'(kind) & mask) << cur_shift);
			end
		end else if (pick < 40) begin
			req = noisy_request(mna_pkg::OP_LOAD_ENTRY, ($urandom_range(0, 4) == 0)
				? $urandom_range(DISPATCH_ENTRIES, 63) : $urandom_range(0, DISPATCH_ENTRIES - 1));
			// a small key pool so that duplicate keys and first-match order matter
			if ($urandom_range(0, 1) == 1)
				req.instr_opcode = mna_pkg::KEY_W'($urandom_range(0, 7));
		end else begin
			req = noisy_request(mna_pkg::OP_STEP,
				loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
			if ($urandom_range(0, 9) < 7)
				req.instr_opcode = slot_keys[$urandom_range(0, DISPATCH_ENTRIES - 1)];
		end
		return req;
	endfunction

	task automatic send_request(input mna_pkg::in_item_t req);
		int gap;
		if ($urandom_range(0, 39) == 0)
			feed_bursty = !feed_bursty;
		gap = feed_bursty ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		if (req.opcode == mna_pkg::OP_LOAD_WORD && !loaded[req.address]) begin
			loaded[req.address] = 1'b1;
			loaded_addrs = {loaded_addrs, int'(req.address)};
		end
		if (req.opcode == mna_pkg::OP_LOAD_ENTRY && req.address < DISPATCH_ENTRIES)
			slot_keys[req.address] = req.instr_opcode;
		if (req.opcode == mna_pkg::OP_STEP)
			steps_sent++;
	endtask

	task automatic load_word(input int addr, input logic [mna_pkg::WORD_W-1:0] word);
		mna_pkg::in_item_t req;
		req = noisy_request(mna_pkg::OP_LOAD_WORD, addr);
		req.micro_word = word;
		send_request(req);
	endtask

	task automatic load_entry(input int slot, input logic [mna_pkg::KEY_W-1:0] key,
			input logic [mna_pkg::ADDR_W-1:0] t1, input logic ok1,
			input logic [mna_pkg::ADDR_W-1:0] t2, input logic ok2,
			input logic [mna_pkg::ADDR_W-1:0] t3, input logic ok3);
		mna_pkg::in_item_t req;
		req = noisy_request(mna_pkg::OP_LOAD_ENTRY, slot);
		req.instr_opcode    = key;
		req.target_one      = t1;
		req.target_one_ok   = ok1;
		req.target_two      = t2;
		req.target_two_ok   = ok2;
		req.target_three    = t3;
		req.target_three_ok = ok3;
		send_request(req);
	endtask

	task automatic step_at(input int addr, input logic [mna_pkg::KEY_W-1:0] key);
		mna_pkg::in_item_t req;
		req = noisy_request(mna_pkg::OP_STEP, addr);
		req.instr_opcode = key;
		send_request(req);
	endtask

	// every request gives a result, so an empty scoreboard means the block is idle
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fields(input logic [mna_pkg::SHIFT_W-1:0] shift,
			input logic [mna_pkg::FWID_W-1:0] width);
		cfg_we <= 1'b1;
		cfg_index <= mna_pkg::CFG_JUMP_SHIFT;
		cfg_data <= shift;
		@(posedge clk);
		cfg_index <= mna_pkg::CFG_JUMP_WIDTH;
		cfg_data <= mna_pkg::SHIFT_W'(width);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_shift = shift;
		cur_width = width;
	endtask

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : drain
		int stall;
		pop = 1'b0;
		drain_bursty = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				drain_bursty = !drain_bursty;
			stall = drain_bursty ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		logic [mna_pkg::SHIFT_W-1:0] shift;
		logic [mna_pkg::FWID_W-1:0]  width;
		mna_pkg::in_item_t           req;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = mna_pkg::CFG_JUMP_SHIFT;
		cfg_data = '0;
		feed_bursty = 1'b0;
		sent = 0;
		steps_sent = 0;
		cur_shift = mna_pkg::JUMP_SHIFT_RESET;
		cur_width = mna_pkg::JUMP_WIDTH_RESET;
		foreach (loaded[i])
			loaded[i] = 1'b0;
		foreach (slot_keys[i])
			slot_keys[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_fields(mna_pkg::JUMP_SHIFT_RESET, mna_pkg::JUMP_WIDTH_RESET);

		// directed: each jump kind, lookup cases and store edges at the reset setting
		load_word(0, {mna_pkg::KIND_ZERO, 28'hFFF_FFFF});
		load_word(STORE_DEPTH - 1, {mna_pkg::KIND_INC, 28'h5A5_A5A5});
		load_word(1, {mna_pkg::KIND_DISP1, 28'hABC_DEF0});
		load_word(2, {mna_pkg::KIND_DISP2, 28'h000_0001});
		load_word(3, {mna_pkg::KIND_DISP3, 28'h000_00FF});
		load_word(4, {4'hF, 28'h123_4567});
		load_word(5, {mna_pkg::KIND_INC, 28'h000_0000});
		step_at(1, 8'h00);           // reset table: key 0 hits slot 0, unsupported
		step_at(1, 8'h55);           // no key matches
		load_entry(0, 8'h55, 6'd10, 1'b1, 6'd20, 1'b0, 6'd63, 1'b1);
		load_entry(1, 8'h55, 6'd1, 1'b1, 6'd1, 1'b1, 6'd1, 1'b1);
		load_entry(DISPATCH_ENTRIES - 1, 8'hFF, 6'd63, 1'b1, 6'd0, 1'b1, 6'd33, 1'b0);
		load_entry(40, 8'hAA, 6'd7, 1'b1, 6'd7, 1'b1, 6'd7, 1'b1);
		step_at(1, 8'h55);           // slot 0 wins over slot 1
		step_at(2, 8'h55);
		step_at(3, 8'h55);
		step_at(3, 8'hFF);
		step_at(1, 8'hAA);           // the entry beyond the table was dropped
		step_at(STORE_DEPTH - 1, 8'h00);
		step_at(5, 8'h00);
		step_at(0, 8'h55);
		step_at(4, 8'h55);
		req = noisy_request(mna_pkg::OP_NONE, $urandom_range(0, 63));
		send_request(req);
		load_word(0, 32'hFFFF_FFFF);
		step_at(0, 8'hFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
			0: begin shift = 5'd28; width = 3'd4; end
			1: begin shift = 5'd0;  width = 3'd1; end
			2: begin shift = 5'd31; width = 3'd4; end
			3: begin shift = 5'd0;  width = 3'd0; end
			4: begin shift = 5'd12; width = 3'd7; end
			5: begin shift = 5'd29; width = 3'd3; end
			6: begin
				shift = mna_pkg::SHIFT_W'($urandom_range(0, 31));
				width = mna_pkg::FWID_W'($urandom_range(1, 4));
			end
			default: begin
				shift = mna_pkg::SHIFT_W'($urandom_range(0, 31));
				width = mna_pkg::FWID_W'($urandom_range(0, 7));
			end
			endcase
			write_fields(shift, width);
			repeat (RANDOM_REQUESTS / PHASES)
				send_request(random_request());
		end
		settle();

		$display("Run covered %0d requests, %0d of them steps, over %0d jump-field settings.",
			sent, steps_sent, PHASES + 1);
		$display("%0d distinct control-store addresses were loaded.", loaded_addrs.size());
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/mna_pkg.sv
src/mna_ram.sv
src/mna_front.sv
src/mna_back.sv
src/microprogram_next_address.sv
test/next_address_checker.sv
test/tb_microprogram_next_address.sv
